@@ rtl/dq_pi_current_controller_unit_defines.svh @@
// Assertion macros shared by the dq PI current controller RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef DQ_PI_CURRENT_CONTROLLER_UNIT_DEFINES_SVH
`define DQ_PI_CURRENT_CONTROLLER_UNIT_DEFINES_SVH

// Check cons in the cycle after ante.
`define DQPI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check cons in the same cycle as ante.
`define DQPI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/dqpi_pkg.sv @@
// Shared types and constants for the dq PI current controller.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package dqpi_pkg;

    localparam int INTEG_BITS = 48;
    localparam int INTEG_FRAC = 32;
    localparam int GAIN_W     = 32;
    localparam int KP_FRAC    = 16;
    localparam int APB_AW     = 5;
    localparam int APB_DW     = 32;

    localparam logic [GAIN_W-1:0] KP_RESET = 32'h0001_0000;
    localparam logic [GAIN_W-1:0] KI_RESET = 32'h0000_0000;

    typedef enum logic [2:0] {
        REG_PROP_GAIN_D  = 3'd0,
        REG_INTEG_GAIN_D = 3'd1,
        REG_PROP_GAIN_Q  = 3'd2,
        REG_INTEG_GAIN_Q = 3'd3,
        REG_UPPER_LIM_D  = 3'd4,
        REG_LOWER_LIM_D  = 3'd5,
        REG_UPPER_LIM_Q  = 3'd6,
        REG_LOWER_LIM_Q  = 3'd7
    } t_reg_idx;

    // sample-wide control that rides along the pipeline
    typedef struct packed {
        logic ext;
        logic clr;
    } t_ctl;

    // sign information of the error for one axis
    typedef struct packed {
        logic err_neg;
        logic pre_pos;
        logic pre_neg;
    } t_axis_flags;

endpackage

`default_nettype wire

@@ rtl/dq_pi_current_controller_unit.sv @@
// dq PI current controller with clamping anti-windup, two axes.
// Top level: instantiates dqpi_regs, dqpi_prod and dqpi_integ; uses dqpi_pkg.
//
// Takes one sample per clock cycle unless o_stall is high and returns its d/q voltage
// commands through three registers (error register loaded at the accepting edge, gain
// product register, result register). The rate is set by the per-axis integrator loop,
// which rounds, saturates, decides clamping and computes the new 48-bit integral
// combinationally, so the next sample sees the updated value.
// A stalled result holds in the output register while up to two later samples wait in
// the earlier stages. The user must write gains and limits over the APB port only while
// no sample is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
`include "dq_pi_current_controller_unit_defines.svh"

module dq_pi_current_controller_unit
    import dqpi_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire        [APB_AW-1:0]        paddr,
    input  wire        [APB_DW-1:0]        pwdata,
    output logic       [APB_DW-1:0]        prdata,
    output logic                           pready,
    input  wire                            i_valid,
    output logic                           o_stall,
    input  wire signed [SAMPLE_WIDTH-1:0]  i_ref_d,
    input  wire signed [SAMPLE_WIDTH-1:0]  i_ref_q,
    input  wire signed [SAMPLE_WIDTH-1:0]  i_meas_d,
    input  wire signed [SAMPLE_WIDTH-1:0]  i_meas_q,
    input  wire                            i_ext_clamp,
    input  wire                            i_integ_reset,
    output logic                           o_valid,
    input  wire                            i_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_volt_d,
    output logic signed [SAMPLE_WIDTH-1:0] o_volt_q,
    output logic                           o_hold_d,
    output logic                           o_hold_q
);

    logic [GAIN_W-1:0]               kp_d, ki_d, kp_q, ki_q;
    logic signed [SAMPLE_WIDTH-1:0]  up_d, lo_d, up_q, lo_q;
    logic signed [SAMPLE_WIDTH+17:0] pv_d, pv_q;
    logic [INTEG_BITS:0]             inc_d, inc_q;
    t_axis_flags                     flags_d, flags_q;

    logic r_in_vld, r_mul_vld, r_out_vld;
    logic n_in_vld, n_mul_vld, n_out_vld;
    t_ctl r_in_ctl, r_mul_ctl;
    logic in_ready, mul_ready, out_ready;
    logic mul_en, out_en;

    assign out_ready = !r_out_vld || !i_stall;
    assign mul_ready = !r_mul_vld || out_ready;
    assign in_ready  = !r_in_vld || mul_ready;
    assign mul_en    = r_in_vld && mul_ready;
    assign out_en    = r_mul_vld && out_ready;

    assign n_in_vld  = in_ready  ? i_valid   : r_in_vld;
    assign n_mul_vld = mul_ready ? r_in_vld  : r_mul_vld;
    assign n_out_vld = out_ready ? r_mul_vld : r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_mul_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_mul_vld <= n_mul_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready) begin
            r_in_ctl.ext <= i_ext_clamp;
            r_in_ctl.clr <= i_integ_reset;
        end
        if (mul_en) begin
            r_mul_ctl <= r_in_ctl;
        end
    end

    dqpi_regs #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_kp_d  (kp_d),
        .o_ki_d  (ki_d),
        .o_kp_q  (kp_q),
        .o_ki_q  (ki_q),
        .o_up_d  (up_d),
        .o_lo_d  (lo_d),
        .o_up_q  (up_q),
        .o_lo_q  (lo_q)
    );

    dqpi_prod #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_prod_d (
        .i_clk     (i_clk),
        .i_ld_err  (in_ready),
        .i_ld_prod (mul_en),
        .i_ref     (i_ref_d),
        .i_meas    (i_meas_d),
        .i_kp      (kp_d),
        .i_ki      (ki_d),
        .o_pv      (pv_d),
        .o_inc     (inc_d),
        .o_flags   (flags_d)
    );

    dqpi_prod #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_prod_q (
        .i_clk     (i_clk),
        .i_ld_err  (in_ready),
        .i_ld_prod (mul_en),
        .i_ref     (i_ref_q),
        .i_meas    (i_meas_q),
        .i_kp      (kp_q),
        .i_ki      (ki_q),
        .o_pv      (pv_q),
        .o_inc     (inc_q),
        .o_flags   (flags_q)
    );

    dqpi_integ #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_integ_d (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (out_en),
        .i_pv    (pv_d),
        .i_inc   (inc_d),
        .i_flags (flags_d),
        .i_ctl   (r_mul_ctl),
        .i_up    (up_d),
        .i_lo    (lo_d),
        .o_volt  (o_volt_d),
        .o_hold  (o_hold_d)
    );

    dqpi_integ #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_integ_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (out_en),
        .i_pv    (pv_q),
        .i_inc   (inc_q),
        .i_flags (flags_q),
        .i_ctl   (r_mul_ctl),
        .i_up    (up_q),
        .i_lo    (lo_q),
        .o_volt  (o_volt_q),
        .o_hold  (o_hold_q)
    );

    assign o_valid = r_out_vld;
    assign o_stall = !in_ready;

    `DQPI_ASSERT_NOW(a_stall_full, o_stall, r_in_vld && r_mul_vld && r_out_vld && i_stall, "input stalled with room in the pipeline")
    `DQPI_ASSERT_NEXT(a_out_fill, out_en, r_out_vld, "result register not filled")
    `DQPI_ASSERT_NEXT(a_no_drop, r_out_vld && i_stall, r_out_vld, "stalled result lost")

endmodule

`default_nettype wire

@@ rtl/dqpi_regs.sv @@
// Configuration register file with an APB-style slave port.
// Depends on dqpi_pkg for register indexes, widths and reset values.
`timescale 1ns / 1ps
`default_nettype none

module dqpi_regs
    import dqpi_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire        [APB_AW-1:0]        paddr,
    input  wire        [APB_DW-1:0]        pwdata,
    output logic       [APB_DW-1:0]        prdata,
    output logic                           pready,
    output logic       [GAIN_W-1:0]        o_kp_d,
    output logic       [GAIN_W-1:0]        o_ki_d,
    output logic       [GAIN_W-1:0]        o_kp_q,
    output logic       [GAIN_W-1:0]        o_ki_q,
    output logic signed [SAMPLE_WIDTH-1:0] o_up_d,
    output logic signed [SAMPLE_WIDTH-1:0] o_lo_d,
    output logic signed [SAMPLE_WIDTH-1:0] o_up_q,
    output logic signed [SAMPLE_WIDTH-1:0] o_lo_q
);

    localparam logic [SAMPLE_WIDTH-1:0] LIM_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] LIM_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic [GAIN_W-1:0]       r_kp_d, r_ki_d, r_kp_q, r_ki_q;
    logic [SAMPLE_WIDTH-1:0] r_up_d, r_lo_d, r_up_q, r_lo_q;
    t_reg_idx                idx;
    logic                    wr;

    assign idx    = t_reg_idx'(paddr[APB_AW-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_d <= KP_RESET;
            r_ki_d <= KI_RESET;
            r_kp_q <= KP_RESET;
            r_ki_q <= KI_RESET;
            r_up_d <= LIM_MAX;
            r_lo_d <= LIM_MIN;
            r_up_q <= LIM_MAX;
            r_lo_q <= LIM_MIN;
        end else if (wr) begin
            case (idx)
                REG_PROP_GAIN_D:  r_kp_d <= pwdata;
                REG_INTEG_GAIN_D: r_ki_d <= pwdata;
                REG_PROP_GAIN_Q:  r_kp_q <= pwdata;
                REG_INTEG_GAIN_Q: r_ki_q <= pwdata;
                REG_UPPER_LIM_D:  r_up_d <= pwdata[SAMPLE_WIDTH-1:0];
                REG_LOWER_LIM_D:  r_lo_d <= pwdata[SAMPLE_WIDTH-1:0];
                REG_UPPER_LIM_Q:  r_up_q <= pwdata[SAMPLE_WIDTH-1:0];
                REG_LOWER_LIM_Q:  r_lo_q <= pwdata[SAMPLE_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_PROP_GAIN_D:  prdata = r_kp_d;
            REG_INTEG_GAIN_D: prdata = r_ki_d;
            REG_PROP_GAIN_Q:  prdata = r_kp_q;
            REG_INTEG_GAIN_Q: prdata = r_ki_q;
            REG_UPPER_LIM_D:  prdata = APB_DW'($signed(r_up_d));
            REG_LOWER_LIM_D:  prdata = APB_DW'($signed(r_lo_d));
            REG_UPPER_LIM_Q:  prdata = APB_DW'($signed(r_up_q));
            REG_LOWER_LIM_Q:  prdata = APB_DW'($signed(r_lo_q));
            default:          prdata = '0;
        endcase
    end

    assign o_kp_d = r_kp_d;
    assign o_ki_d = r_ki_d;
    assign o_kp_q = r_kp_q;
    assign o_ki_q = r_ki_q;
    assign o_up_d = $signed(r_up_d);
    assign o_lo_d = $signed(r_lo_d);
    assign o_up_q = $signed(r_up_q);
    assign o_lo_q = $signed(r_lo_q);

endmodule

`default_nettype wire

@@ rtl/dqpi_prod.sv @@
// Error and gain product stages of one axis: error register, then the
// rounded proportional term and the capped integral increment. Uses dqpi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dqpi_prod
    import dqpi_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire                              i_clk,
    input  wire                              i_ld_err,
    input  wire                              i_ld_prod,
    input  wire signed [SAMPLE_WIDTH-1:0]    i_ref,
    input  wire signed [SAMPLE_WIDTH-1:0]    i_meas,
    input  wire        [GAIN_W-1:0]          i_kp,
    input  wire        [GAIN_W-1:0]          i_ki,
    output logic signed [SAMPLE_WIDTH+17:0]  o_pv,
    output logic       [INTEG_BITS:0]        o_inc,
    output t_axis_flags                      o_flags
);

    localparam int W   = SAMPLE_WIDTH;
    localparam int PW  = W + GAIN_W;
    localparam int PRW = PW + 1;
    localparam int PMW = PRW - KP_FRAC;
    localparam int IW  = INTEG_BITS + 1;
    localparam int MW  = (PW > IW) ? PW : IW;
    localparam logic [PRW-1:0] P_HALF  = PRW'(1) << (KP_FRAC - 1);
    localparam logic [MW-1:0]  INC_CAP = MW'(1) << INTEG_BITS;

    logic signed [W:0]     err;
    logic                  r_neg;
    logic [W-1:0]          r_mag;
    logic [W:0]            err_abs;
    logic [PW-1:0]         pprod;
    logic [PRW-1:0]        prnd;
    logic [PMW-1:0]        pm;
    logic [PW-1:0]         iprod;
    logic [MW-1:0]         iprod_x;
    logic                  ki_nz;
    logic signed [PMW:0]   n_pv;
    logic [IW-1:0]         n_inc;
    t_axis_flags           n_flags;
    logic signed [PMW:0]   r_pv;
    logic [IW-1:0]         r_inc;
    t_axis_flags           r_flags;

    assign err     = $signed({i_ref[W-1], i_ref}) - $signed({i_meas[W-1], i_meas});
    assign err_abs = err[W] ? -err : err;

    always_ff @(posedge i_clk) begin
        if (i_ld_err) begin
            r_neg <= err[W];
            r_mag <= err_abs[W-1:0];
        end
    end

    assign pprod   = r_mag * i_kp;
    assign prnd    = {1'b0, pprod} + P_HALF;
    assign pm      = prnd[PRW-1:KP_FRAC];
    assign n_pv    = r_neg ? -$signed({1'b0, pm}) : $signed({1'b0, pm});

    assign iprod   = r_mag * i_ki;
    assign iprod_x = MW'(iprod);
    assign n_inc   = (iprod_x > INC_CAP) ? INC_CAP[IW-1:0] : iprod_x[IW-1:0];

    assign ki_nz           = (i_ki != '0);
    assign n_flags.err_neg = r_neg;
    assign n_flags.pre_pos = !r_neg && (r_mag != '0) && ki_nz;
    assign n_flags.pre_neg = r_neg && ki_nz;

    always_ff @(posedge i_clk) begin
        if (i_ld_prod) begin
            r_pv    <= n_pv;
            r_inc   <= n_inc;
            r_flags <= n_flags;
        end
    end

    assign o_pv    = r_pv;
    assign o_inc   = r_inc;
    assign o_flags = r_flags;

endmodule

`default_nettype wire

@@ rtl/dqpi_integ.sv @@
// Integrator loop of one axis: integral rounding, output saturation,
// clamping decision, integral update and the result register. Uses dqpi_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "dq_pi_current_controller_unit_defines.svh"

module dqpi_integ
    import dqpi_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_adv,
    input  wire signed [SAMPLE_WIDTH+17:0]   i_pv,
    input  wire        [INTEG_BITS:0]        i_inc,
    input  t_axis_flags                      i_flags,
    input  t_ctl                             i_ctl,
    input  wire signed [SAMPLE_WIDTH-1:0]    i_up,
    input  wire signed [SAMPLE_WIDTH-1:0]    i_lo,
    output logic signed [SAMPLE_WIDTH-1:0]   o_volt,
    output logic                             o_hold
);

    localparam int W   = SAMPLE_WIDTH;
    localparam int UW  = W + 19;
    localparam int IMW = INTEG_BITS - INTEG_FRAC + 1;
    localparam int SW  = INTEG_BITS + 3;
    localparam logic [INTEG_BITS:0] I_HALF = (INTEG_BITS+1)'(1) << (INTEG_FRAC - 1);
    localparam logic signed [SW-1:0] SUM_HI = SW'({1'b0, {(INTEG_BITS-1){1'b1}}});
    localparam logic signed [SW-1:0] SUM_LO = -SUM_HI - SW'(1);
    localparam logic [INTEG_BITS-1:0] INT_HI = {1'b0, {(INTEG_BITS-1){1'b1}}};
    localparam logic [INTEG_BITS-1:0] INT_LO = {1'b1, {(INTEG_BITS-1){1'b0}}};

    logic signed [INTEG_BITS-1:0] r_integ;
    logic signed [INTEG_BITS-1:0] n_integ;
    logic signed [W-1:0]          r_volt;
    logic                         r_hold;
    logic                         ineg;
    logic [INTEG_BITS-1:0]        iabs;
    logic [INTEG_BITS:0]          irnd;
    logic [IMW-1:0]               im;
    logic signed [IMW:0]          isv;
    logic signed [UW-1:0]         unsat;
    logic signed [UW-1:0]         up_x;
    logic signed [UW-1:0]         lo_x;
    logic                         gt;
    logic                         lt;
    logic signed [W-1:0]          volt;
    logic                         upos;
    logic                         uneg;
    logic                         uzero;
    logic                         pre_zero;
    logic                         internal;
    logic                         hold;
    logic signed [INTEG_BITS+1:0] incs;
    logic signed [SW-1:0]         sum;
    logic signed [INTEG_BITS-1:0] sat;

    assign ineg  = r_integ[INTEG_BITS-1];
    assign iabs  = ineg ? -r_integ : r_integ;
    assign irnd  = {1'b0, iabs} + I_HALF;
    assign im    = irnd[INTEG_BITS:INTEG_FRAC];
    assign isv   = ineg ? -$signed({1'b0, im}) : $signed({1'b0, im});

    assign unsat = UW'(i_pv) + UW'(isv);
    assign up_x  = UW'(i_up);
    assign lo_x  = UW'(i_lo);
    assign gt    = unsat > up_x;
    assign lt    = unsat < lo_x;
    assign volt  = gt ? i_up : (lt ? i_lo : unsat[W-1:0]);

    assign uneg     = unsat[UW-1];
    assign uzero    = (unsat == '0);
    assign upos     = !uneg && !uzero;
    assign pre_zero = !i_flags.pre_pos && !i_flags.pre_neg;
    assign internal = (gt || lt) && ((i_flags.pre_pos && upos)
                                  || (i_flags.pre_neg && uneg)
                                  || (pre_zero && uzero));
    assign hold     = i_ctl.ext || internal;

    assign incs = i_flags.err_neg ? -$signed({1'b0, i_inc}) : $signed({1'b0, i_inc});
    assign sum  = SW'(r_integ) + SW'(incs);

    always_comb begin
        if (sum > SUM_HI) begin
            sat = INT_HI;
        end else if (sum < SUM_LO) begin
            sat = INT_LO;
        end else begin
            sat = sum[INTEG_BITS-1:0];
        end
        if (i_ctl.clr) begin
            n_integ = '0;
        end else if (hold) begin
            n_integ = r_integ;
        end else begin
            n_integ = sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (i_adv) begin
            r_integ <= n_integ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_volt <= volt;
            r_hold <= hold;
        end
    end

    assign o_volt = r_volt;
    assign o_hold = r_hold;

    `DQPI_ASSERT_NEXT(a_ext_holds, i_adv && i_ctl.ext, r_hold, "external clamp did not hold")
    `DQPI_ASSERT_NEXT(a_hold_keeps, i_adv && hold && !i_ctl.clr, $stable(r_integ), "integral moved while held")
    `DQPI_ASSERT_NEXT(a_clr_zero, i_adv && i_ctl.clr, r_integ == '0, "integral not cleared")
    `DQPI_ASSERT_NEXT(a_volt_in_lim, i_adv && (i_lo <= i_up), (r_volt <= $past(i_up)) && (r_volt >= $past(i_lo)), "voltage outside limits")

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the dq PI current controller (dq_pi_current_controller_unit).
// Drives a directed table and then random samples; checks every voltage command against
// table values or a bit-accurate predictor of both PI axes. Depends on dqpi_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
    import dqpi_pkg::*;

    localparam int SW              = 16;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLDOFF_CYCLES  = 60;
    localparam int N_PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int TAIL_CYCLES     = 8;
    localparam int N_ROWS          = 28;

    localparam longint ACC_MAX = (64'sd1 <<< (INTEG_BITS - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam longint unsigned INC_CAP = 64'd1 << INTEG_BITS;

    typedef enum bit {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    typedef struct packed {
        logic signed [SW-1:0] ref_d;
        logic signed [SW-1:0] meas_d;
        logic signed [SW-1:0] ref_q;
        logic signed [SW-1:0] meas_q;
        logic                 ext;
        logic                 clr;
    } t_sample;

    typedef struct packed {
        logic signed [SW-1:0] volt_d;
        logic signed [SW-1:0] volt_q;
        logic                 hold_d;
        logic                 hold_q;
    } t_volt_cmd;

    typedef struct packed {
        t_row_kind            kind;
        t_reg_idx             reg_idx;
        logic [31:0]          wdata;
        logic signed [SW-1:0] ref_d;
        logic signed [SW-1:0] meas_d;
        logic signed [SW-1:0] ref_q;
        logic signed [SW-1:0] meas_q;
        logic                 ext;
        logic                 clr;
        logic                 typed;
        logic signed [SW-1:0] volt_d;
        logic signed [SW-1:0] volt_q;
        logic                 hold_d;
        logic                 hold_q;
    } t_row;

    t_row plan [N_ROWS] = '{
        '{ROW_SAMPLE, REG_PROP_GAIN_D, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0},
        '{ROW_SAMPLE, REG_PROP_GAIN_D, 0, 32767, -32768, -32768, 32767, 0, 0,
          1, 32767, -32768, 0, 0},
        '{ROW_SAMPLE, REG_PROP_GAIN_D, 0, 100, 40, -5, 7, 0, 0, 1, 60, -12, 0, 0},
        '{ROW_SAMPLE, REG_PROP_GAIN_D, 0, -1, 0, 0, -1, 1, 1, 1, -1, 1, 1, 1},
        '{ROW_SAMPLE, REG_PROP_GAIN_D, 0, 32767, 32767, -32768, -32768, 0, 0,
          1, 0, 0, 0, 0},
        '{ROW_SAMPLE, REG_PROP_GAIN_D, 0, -32768, 32767, 32767, -32768, 0, 0,
          1, -32768, 32767, 0, 0},
        '{ROW_WRITE, REG_PROP_GAIN_D, 32'h0000_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_INTEG_GAIN_D, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_PROP_GAIN_Q, 32'h0000_8000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_INTEG_GAIN_Q, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_SAMPLE, REG_PROP_GAIN_D, 0, 32767, -32768, 1, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_SAMPLE, REG_PROP_GAIN_D, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_SAMPLE, REG_PROP_GAIN_D, 0, -32768, 32767, -1, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_SAMPLE, REG_PROP_GAIN_D, 0, -32768, 32767, -1, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_SAMPLE, REG_PROP_GAIN_D, 0, 0, 0, 0, 3, 0, 1, 0, 0, 0, 0, 0},
        '{ROW_SAMPLE, REG_PROP_GAIN_D, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_UPPER_LIM_D, 32'd100, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_LOWER_LIM_D, -100, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_UPPER_LIM_Q, -32768, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_LOWER_LIM_Q, 32'd32767, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_PROP_GAIN_D, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_INTEG_GAIN_D, 32'h0100_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_PROP_GAIN_Q, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_INTEG_GAIN_Q, 32'h0000_0001, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_SAMPLE, REG_PROP_GAIN_D, 0, 1000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_SAMPLE, REG_PROP_GAIN_D, 0, 0, 1000, 50, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_SAMPLE, REG_PROP_GAIN_D, 0, 40, 0, -3, 0, 1, 0, 0, 0, 0, 0, 0},
        '{ROW_SAMPLE, REG_PROP_GAIN_D, 0, -32768, 32767, 32767, -32768, 1, 1,
          0, 0, 0, 0, 0}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic signed [SW-1:0] i_ref_d = '0;
    logic signed [SW-1:0] i_ref_q = '0;
    logic signed [SW-1:0] i_meas_d = '0;
    logic signed [SW-1:0] i_meas_q = '0;
    logic                 i_ext_clamp = 1'b0;
    logic                 i_integ_reset = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic signed [SW-1:0] o_volt_d;
    logic signed [SW-1:0] o_volt_q;
    logic                 o_hold_d;
    logic                 o_hold_q;

    bit [31:0]            kp_gain   [2] = '{KP_RESET, KP_RESET};
    bit [31:0]            ki_gain   [2] = '{KI_RESET, KI_RESET};
    logic signed [SW-1:0] upper_lim [2] = '{{1'b0, {(SW-1){1'b1}}}, {1'b0, {(SW-1){1'b1}}}};
    logic signed [SW-1:0] lower_lim [2] = '{{1'b1, {(SW-1){1'b0}}}, {1'b1, {(SW-1){1'b0}}}};
    longint               integ     [2] = '{0, 0};

    t_volt_cmd pending_cmds [$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    bit        holdoff_req = 1'b0;

    dq_pi_current_controller_unit #(
        .SAMPLE_WIDTH(SW)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_ref_d       (i_ref_d),
        .i_ref_q       (i_ref_q),
        .i_meas_d      (i_meas_d),
        .i_meas_q      (i_meas_q),
        .i_ext_clamp   (i_ext_clamp),
        .i_integ_reset (i_integ_reset),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_volt_d      (o_volt_d),
        .o_volt_q      (o_volt_q),
        .o_hold_d      (o_hold_d),
        .o_hold_q      (o_hold_q)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("dq_pi_current_controller_unit: mismatch");
            $finish;
        end
    end

    function automatic logic signed [SW-1:0] axis_command(
        input longint err, input bit [31:0] kp, input bit [31:0] ki,
        input longint up, input longint lo, input bit ext,
        inout longint acc, output bit held);
        bit                neg;
        longint unsigned   mag, prop_mag, acc_mag, inc;
        longint            prop, acc_term, unsat, sat, sum;
        int                pre, sgn;
        neg      = err < 0;
        mag      = neg ? -err : err;
        prop_mag = (mag * kp + 64'd32768) >> KP_FRAC;
        prop     = neg ? -$signed(prop_mag) : $signed(prop_mag);
        acc_mag  = (acc < 0) ? -acc : acc;
        acc_mag  = (acc_mag + (64'd1 << (INTEG_FRAC - 1))) >> INTEG_FRAC;
        acc_term = (acc < 0) ? -$signed(acc_mag) : $signed(acc_mag);
        unsat    = acc_term + prop;
        sat      = unsat;
        if (unsat > up) begin
            sat = up;
        end else if (unsat < lo) begin
            sat = lo;
        end
        pre  = (err == 0 || ki == 0) ? 0 : (neg ? -1 : 1);
        sgn  = (unsat > 0) ? 1 : ((unsat < 0) ? -1 : 0);
        held = ext || (sat != unsat && pre == sgn);
        if (!held) begin
            inc = mag * ki;
            if (inc > INC_CAP) begin
                inc = INC_CAP;
            end
            sum = acc + (neg ? -$signed(inc) : $signed(inc));
            if (sum > ACC_MAX) begin
                sum = ACC_MAX;
            end else if (sum < ACC_MIN) begin
                sum = ACC_MIN;
            end
            acc = sum;
        end
        return sat[SW-1:0];
    endfunction

    function automatic t_volt_cmd predict_command(input t_sample s);
        t_volt_cmd c;
        bit        hd, hq;
        longint    err_d, err_q;
        err_d    = longint'($signed(s.ref_d)) - longint'($signed(s.meas_d));
        err_q    = longint'($signed(s.ref_q)) - longint'($signed(s.meas_q));
        c.volt_d = axis_command(err_d, kp_gain[0], ki_gain[0], upper_lim[0], lower_lim[0],
                                s.ext, integ[0], hd);
        c.volt_q = axis_command(err_q, kp_gain[1], ki_gain[1], upper_lim[1], lower_lim[1],
                                s.ext, integ[1], hq);
        c.hold_d = hd;
        c.hold_q = hq;
        if (s.clr) begin
            integ[0] = 0;
            integ[1] = 0;
        end
        return c;
    endfunction

    function automatic bit [31:0] pick_gain(input bit [31:0] span);
        case ($urandom_range(4))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(span);
        endcase
    endfunction

    function automatic void pick_limits(output logic signed [SW-1:0] up,
                                        output logic signed [SW-1:0] lo);
        logic signed [SW-1:0] a, b;
        a = $urandom;
        b = $urandom;
        case ($urandom_range(4))
            0: begin
                up = {1'b0, {(SW-1){1'b1}}};
                lo = {1'b1, {(SW-1){1'b0}}};
            end
            1: begin
                up = $urandom_range(3000);
                lo = -$signed({1'b0, SW'($urandom_range(3000))});
            end
            2: begin
                up = (a > b) ? a : b;
                lo = (a > b) ? b : a;
            end
            3: begin
                up = (a > b) ? b : a;
                lo = (a > b) ? a : b;
            end
            default: begin
                up = {1'b1, {(SW-1){1'b0}}};
                lo = {1'b0, {(SW-1){1'b1}}};
            end
        endcase
    endfunction

    function automatic t_sample random_sample();
        t_sample s;
        int      dd, dq;
        s.ref_d = $urandom;
        s.ref_q = $urandom;
        dd      = $urandom_range(600);
        dq      = $urandom_range(600);
        dd      = dd - 300;
        dq      = dq - 300;
        if ($urandom_range(9) < 2) begin
            s.meas_d = $urandom;
            s.meas_q = $urandom;
        end else begin
            s.meas_d = s.ref_d - dd;
            s.meas_q = s.ref_q - dq;
        end
        s.ext = ($urandom_range(7) == 0);
        s.clr = ($urandom_range(24) == 0);
        return s;
    endfunction

    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_cmds.size() != 0);
    endtask

    task automatic program_reg(input t_reg_idx idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PROP_GAIN_D:  kp_gain[0]   = val;
            REG_INTEG_GAIN_D: ki_gain[0]   = val;
            REG_PROP_GAIN_Q:  kp_gain[1]   = val;
            REG_INTEG_GAIN_Q: ki_gain[1]   = val;
            REG_UPPER_LIM_D:  upper_lim[0] = val[SW-1:0];
            REG_LOWER_LIM_D:  lower_lim[0] = val[SW-1:0];
            REG_UPPER_LIM_Q:  upper_lim[1] = val[SW-1:0];
            REG_LOWER_LIM_Q:  lower_lim[1] = val[SW-1:0];
            default: ;
        endcase
    endtask

    task automatic program_random_setting();
        logic signed [SW-1:0] up, lo;
        settle();
        program_reg(REG_PROP_GAIN_D, pick_gain(32'h0004_0000));
        program_reg(REG_INTEG_GAIN_D, pick_gain(32'h0400_0000));
        program_reg(REG_PROP_GAIN_Q, pick_gain(32'h0004_0000));
        program_reg(REG_INTEG_GAIN_Q, pick_gain(32'h0400_0000));
        pick_limits(up, lo);
        program_reg(REG_UPPER_LIM_D, 32'($signed(up)));
        program_reg(REG_LOWER_LIM_D, 32'($signed(lo)));
        pick_limits(up, lo);
        program_reg(REG_UPPER_LIM_Q, 32'($signed(up)));
        program_reg(REG_LOWER_LIM_Q, 32'($signed(lo)));
    endtask

    task automatic send_sample(input t_sample s, input bit typed, input t_volt_cmd typed_cmd);
        t_volt_cmd c;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_ref_d       <= s.ref_d;
        i_meas_d      <= s.meas_d;
        i_ref_q       <= s.ref_q;
        i_meas_q      <= s.meas_q;
        i_ext_clamp   <= s.ext;
        i_integ_reset <= s.clr;
        do @(posedge i_clk); while (o_stall);
        c = predict_command(s);
        pending_cmds.push_back(typed ? typed_cmd : c);
    endtask

    initial begin : receiver
        int holdoff_left;
        holdoff_left = 0;
        forever begin
            @(posedge i_clk);
            if (holdoff_req) begin
                holdoff_req  = 1'b0;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_commands
        t_volt_cmd want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_cmds.size() == 0) begin
                $error("voltage command with none expected: d=%0d q=%0d", o_volt_d, o_volt_q);
                mismatch_count++;
            end else begin
                want = pending_cmds.pop_front();
                if (want.volt_d !== o_volt_d) begin
                    $error("volt_d: expected %0d, got %0d", want.volt_d, o_volt_d);
                    mismatch_count++;
                end
                if (want.volt_q !== o_volt_q) begin
                    $error("volt_q: expected %0d, got %0d", want.volt_q, o_volt_q);
                    mismatch_count++;
                end
                if (want.hold_d !== o_hold_d) begin
                    $error("hold_d: expected %0d, got %0d", want.hold_d, o_hold_d);
                    mismatch_count++;
                end
                if (want.hold_q !== o_hold_q) begin
                    $error("hold_q: expected %0d, got %0d", want.hold_q, o_hold_q);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_sample   s;
        t_volt_cmd t;
        send_idle_pct = 33;
        recv_idle_pct = 83;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_WRITE) begin
                settle();
                program_reg(plan[r].reg_idx, plan[r].wdata);
            end else begin
                s.ref_d  = plan[r].ref_d;
                s.meas_d = plan[r].meas_d;
                s.ref_q  = plan[r].ref_q;
                s.meas_q = plan[r].meas_q;
                s.ext    = plan[r].ext;
                s.clr    = plan[r].clr;
                t.volt_d = plan[r].volt_d;
                t.volt_q = plan[r].volt_q;
                t.hold_d = plan[r].hold_d;
                t.hold_q = plan[r].hold_q;
                send_sample(s, plan[r].typed, t);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            program_random_setting();
            case (ph / 2)
                0: begin
                    send_idle_pct = 33;
                    recv_idle_pct = 83;
                end
                1: begin
                    send_idle_pct = 83;
                    recv_idle_pct = 33;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // back up the pipeline with a long output stall
                if (ph == N_PHASES - 2 && k == 30) begin
                    holdoff_req = 1'b1;
                end
                if (ph == N_PHASES - 1 && k == 45) begin
                    settle();
                end
                send_sample(random_sample(), 1'b0, t);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_cmds.size() == 0) begin
            $display("dq_pi_current_controller_unit: match");
        end else begin
            $display("dq_pi_current_controller_unit: mismatch");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/dqpi_pkg.sv
rtl/dqpi_regs.sv
rtl/dqpi_prod.sv
rtl/dqpi_integ.sv
rtl/dq_pi_current_controller_unit.sv
verif/tb.sv
